// ----- sv/lsh_pkg.sv -----
`timescale 1ns / 1ps
package lsh_pkg;

    localparam int METRIC_W    = 16;
    localparam int LEVEL_W     = 2;
    localparam int LCOUNT_W    = 3;
    localparam int TCOUNT_W    = 2;
    localparam int TABLE_SLOTS = 3;
    localparam int TABLE_W     = 48;
    localparam int RATIO_W     = 16;
    localparam int FACTOR_W    = RATIO_W + 1;
    localparam int PROD_W      = METRIC_W + FACTOR_W;
    localparam int REG_IDX_W   = 3;

    localparam logic [RATIO_W-1:0]  RATIO_MAX = 16'd64880;
    localparam logic [FACTOR_W-1:0] ONE_Q16   = 17'd65536;

    // policy codes
    localparam logic [1:0] MODE_FIXED    = 2'd0;
    localparam logic [1:0] MODE_DISTANCE = 2'd1;
    localparam logic [1:0] MODE_ERROR    = 2'd2;

    // command codes
    localparam logic [1:0] CMD_DISTANCE = 2'd0;
    localparam logic [1:0] CMD_ERROR    = 2'd1;
    localparam logic [1:0] CMD_QUERY    = 2'd2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_LOD_MODE      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LEVEL_COUNT   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FIXED_LEVEL   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BAND_RATIO    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PRIMARY_COUNT = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_PRIMARY_TABLE = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_EXIT_COUNT    = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_EXIT_TABLE    = 3'd7;

    typedef struct packed {
        logic [1:0]          lod_mode;
        logic [LCOUNT_W-1:0] level_count;
        logic [LEVEL_W-1:0]  fixed_level;
        logic [RATIO_W-1:0]  band_ratio;
        logic [TCOUNT_W-1:0] primary_count;
        logic [TABLE_W-1:0]  primary_table;
        logic [TCOUNT_W-1:0] exit_count;
        logic [TABLE_W-1:0]  exit_table;
    } cfg_t;

    typedef struct packed {
        logic               level_valid;
        logic [LEVEL_W-1:0] active_level;
        logic               applied;
        logic [LEVEL_W-1:0] next_level;
        logic               next_known;
    } res_t;

endpackage

// ----- sv/lsh_cfg_regs.sv -----
`timescale 1ns / 1ps
module lsh_cfg_regs #(
    parameter int MAX_LEVELS = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [lsh_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [lsh_pkg::TABLE_W-1:0]   cfg_data,
    output lsh_pkg::cfg_t                 cfg
);
    import lsh_pkg::*;

    localparam int CAP_INT = (MAX_LEVELS - 1 < TABLE_SLOTS) ? MAX_LEVELS - 1 : TABLE_SLOTS;
    localparam logic [TCOUNT_W-1:0] COUNT_CAP  = TCOUNT_W'(CAP_INT);
    localparam logic [LCOUNT_W-1:0] LEVELS_CAP = LCOUNT_W'(MAX_LEVELS);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_LOD_MODE:      cfg_next.lod_mode = cfg_data[1:0];
                REG_LEVEL_COUNT:   cfg_next.level_count =
                    (cfg_data[LCOUNT_W-1:0] > LEVELS_CAP) ? LEVELS_CAP : cfg_data[LCOUNT_W-1:0];
                REG_FIXED_LEVEL:   cfg_next.fixed_level = cfg_data[LEVEL_W-1:0];
                REG_BAND_RATIO:    cfg_next.band_ratio =
                    (cfg_data[RATIO_W-1:0] > RATIO_MAX) ? RATIO_MAX : cfg_data[RATIO_W-1:0];
                // counts are stored already capped to the usable table slots
                REG_PRIMARY_COUNT: cfg_next.primary_count =
                    (cfg_data[TCOUNT_W-1:0] > COUNT_CAP) ? COUNT_CAP : cfg_data[TCOUNT_W-1:0];
                REG_PRIMARY_TABLE: cfg_next.primary_table = cfg_data;
                REG_EXIT_COUNT:    cfg_next.exit_count =
                    (cfg_data[TCOUNT_W-1:0] > COUNT_CAP) ? COUNT_CAP : cfg_data[TCOUNT_W-1:0];
                REG_EXIT_TABLE:    cfg_next.exit_table = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/lsh_resolve.sv -----
`timescale 1ns / 1ps
module lsh_resolve #(
    parameter int LIMIT_BITS = 16
) (
    input  lsh_pkg::cfg_t                cfg,
    input  logic [1:0]                   cmd,
    input  logic [lsh_pkg::METRIC_W-1:0] metric,
    input  logic [lsh_pkg::LEVEL_W-1:0]  cur_level,
    input  logic                         cur_known,
    output lsh_pkg::res_t                res
);
    import lsh_pkg::*;

    logic [METRIC_W-1:0] ptab [0:3];
    logic [METRIC_W-1:0] etab [0:3];
    logic [LEVEL_W-1:0]  dist_base;
    logic [LEVEL_W-1:0]  err_base;
    logic [LEVEL_W-1:0]  base;
    logic [LEVEL_W-1:0]  bnd;
    logic [LEVEL_W-1:0]  hyst_level;
    logic [LEVEL_W-1:0]  new_level;
    logic [FACTOR_W-1:0] factor;
    logic [PROD_W-1:0]   prod;
    logic [PROD_W-1:0]   lhs;
    logic                going_up;
    logic                is_dist;
    logic                do_eval;
    logic [LCOUNT_W-1:0] lc_m1;
    logic                go_d;
    logic                go_e;

    // unpack both tables, running max up to the entry count
    always_comb begin
        ptab[3] = '0;
        etab[3] = '0;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            ptab[i] = METRIC_W'(cfg.primary_table[i*LIMIT_BITS +: LIMIT_BITS]);
            etab[i] = METRIC_W'(cfg.exit_table[i*LIMIT_BITS +: LIMIT_BITS]);
            if (i > 0) begin
                if (TCOUNT_W'(i) < cfg.primary_count && ptab[i] < ptab[i-1])
                    ptab[i] = ptab[i-1];
                if (TCOUNT_W'(i) < cfg.exit_count && etab[i] < etab[i-1])
                    etab[i] = etab[i-1];
            end
        end
    end

    // base level: how far the metric walks up the table
    always_comb begin
        dist_base = '0;
        err_base  = '0;
        go_d      = 1'b1;
        go_e      = 1'b1;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (go_d && LCOUNT_W'(i + 1) < cfg.level_count && TCOUNT_W'(i) < cfg.primary_count
                && metric >= ptab[i]) begin
                dist_base = LEVEL_W'(i + 1);
            end else begin
                go_d = 1'b0;
            end
            if (go_e && LCOUNT_W'(i + 1) < cfg.level_count && TCOUNT_W'(i) < cfg.primary_count
                && metric < ptab[i]) begin
                err_base = LEVEL_W'(i + 1);
            end else begin
                go_e = 1'b0;
            end
        end
    end

    assign is_dist  = (cfg.lod_mode == MODE_DISTANCE);
    assign base     = is_dist ? dist_base : err_base;
    assign going_up = (base > cur_level);
    assign bnd      = going_up ? cur_level : base;

    // exact band test: metric*65536 against t*(65536 +/- r)
    assign factor = going_up ? (ONE_Q16 + FACTOR_W'(cfg.band_ratio))
                             : (ONE_Q16 - FACTOR_W'(cfg.band_ratio));
    assign prod   = PROD_W'(ptab[bnd]) * PROD_W'(factor);
    assign lhs    = {1'b0, metric, 16'd0};

    always_comb begin
        hyst_level = base;
        if (!cur_known || base == cur_level) begin
            hyst_level = cur_known ? cur_level : base;
        end else if (is_dist) begin
            if (TCOUNT_W'(bnd) < cfg.primary_count && bnd != 2'd3) begin
                if (going_up)
                    hyst_level = (lhs >= prod) ? base : cur_level;
                else
                    hyst_level = (lhs <= prod) ? base : cur_level;
            end
        end else begin
            if (TCOUNT_W'(bnd) < cfg.primary_count && TCOUNT_W'(bnd) < cfg.exit_count
                && bnd != 2'd3) begin
                if (going_up)
                    hyst_level = (metric <= etab[bnd]) ? base : cur_level;
                else
                    hyst_level = (metric >= ptab[bnd]) ? base : cur_level;
            end
        end
    end

    assign do_eval = (cfg.level_count != '0) &&
                     ((cmd == CMD_DISTANCE && cfg.lod_mode == MODE_DISTANCE) ||
                      (cmd == CMD_ERROR && cfg.lod_mode == MODE_ERROR));
    assign new_level = do_eval ? hyst_level : cur_level;
    assign lc_m1     = cfg.level_count - 3'd1;

    always_comb begin
        res.applied      = do_eval;
        res.next_level   = new_level;
        res.next_known   = do_eval | cur_known;
        res.level_valid  = 1'b0;
        res.active_level = '0;
        if (cfg.level_count != '0) begin
            if (cfg.lod_mode == MODE_FIXED) begin
                res.level_valid  = 1'b1;
                res.active_level = (LCOUNT_W'(cfg.fixed_level) < cfg.level_count)
                                   ? cfg.fixed_level : lc_m1[LEVEL_W-1:0];
            end else if (res.next_known) begin
                res.level_valid  = 1'b1;
                res.active_level = (LCOUNT_W'(new_level) < cfg.level_count)
                                   ? new_level : lc_m1[LEVEL_W-1:0];
            end
        end
    end

endmodule

// ----- sv/lod_select_hysteresis.sv -----
`timescale 1ns / 1ps
// level-of-detail selector with hysteresis
//
// s_ channel: one word per request; s_tuser carries the command (evaluate distance,
// evaluate screen error, query) and s_tdata the UQ8.8 metric
// m_ channel: one result word per request; m_tuser flags level_valid and applied,
// m_tdata carries the resolved level
// cfg channel: register writes by index, always ready; any write drops the current
// selection, so the next evaluation starts from the base level
//
// the input register feeds one pass through the threshold compares and a single 16x17
// band multiply, and the result register loads together with the stored level;
// throughput is one word per cycle while m_tready stays high, and then
// the input side never stalls; when the receiver stalls
// the result register holds and one more word can wait in the input register
// before s_tready drops
// reset clears the valid flags, the configuration registers and tables and the stored
// selection; results are invalid until levels are configured
module lod_select_hysteresis #(
    parameter int MAX_LEVELS = 4,
    parameter int LIMIT_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,  // metric
    input  logic [1:0]                    s_tuser,  // cmd
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,  // active_level, zero fill
    output logic [1:0]                    m_tuser,  // level_valid, applied
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lsh_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [lsh_pkg::TABLE_W-1:0]   cfg_data
);
    import lsh_pkg::*;

    cfg_t cfg;
    res_t res;
    logic cfg_we;
    logic advance;

    logic                in_valid_reg,  in_valid_next;
    logic [1:0]          in_cmd_reg,    in_cmd_next;
    logic [METRIC_W-1:0] in_metric_reg, in_metric_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_lvalid_reg, out_lvalid_next;
    logic [LEVEL_W-1:0]  out_level_reg, out_level_next;
    logic                out_applied_reg, out_applied_next;
    logic [LEVEL_W-1:0]  cur_level_reg, cur_level_next;
    logic                cur_known_reg, cur_known_next;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid & cfg_ready;

    lsh_cfg_regs #(.MAX_LEVELS(MAX_LEVELS)) u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    lsh_resolve #(.LIMIT_BITS(LIMIT_BITS)) u_resolve (
        .cfg      (cfg),
        .cmd      (in_cmd_reg),
        .metric   (in_metric_reg),
        .cur_level(cur_level_reg),
        .cur_known(cur_known_reg),
        .res      (res)
    );

    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;

    always_comb begin
        in_valid_next    = in_valid_reg;
        in_cmd_next      = in_cmd_reg;
        in_metric_next   = in_metric_reg;
        out_valid_next   = out_valid_reg;
        out_lvalid_next  = out_lvalid_reg;
        out_level_next   = out_level_reg;
        out_applied_next = out_applied_reg;
        cur_level_next   = cur_level_reg;
        cur_known_next   = cur_known_reg;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;
        if (advance) begin
            in_valid_next    = 1'b0;
            out_valid_next   = 1'b1;
            out_lvalid_next  = res.level_valid;
            out_level_next   = res.active_level;
            out_applied_next = res.applied;
            cur_level_next   = res.next_level;
            cur_known_next   = res.next_known;
        end
        if (s_tvalid && s_tready) begin
            in_valid_next  = 1'b1;
            in_cmd_next    = s_tuser;
            in_metric_next = s_tdata;
        end
        if (cfg_we)
            cur_known_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cur_level_reg <= '0;
            cur_known_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            cur_level_reg <= cur_level_next;
            cur_known_reg <= cur_known_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_cmd_reg      <= in_cmd_next;
        in_metric_reg   <= in_metric_next;
        out_lvalid_reg  <= out_lvalid_next;
        out_level_reg   <= out_level_next;
        out_applied_reg <= out_applied_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_level_reg};
    assign m_tuser  = {out_applied_reg, out_lvalid_reg};

`ifndef SYNTHESIS
    a_invalid_level_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[1:0] == 2'd0)
        else $error("invalid result carries a nonzero level");

    a_applied_is_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("applied result without a valid level");

    a_cfg_drops_selection: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> !cur_known_reg)
        else $error("selection survived a register write");

    a_level_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(cur_level_reg))
        else $error("stored level changed without a word passing");
`endif

endmodule

// ----- test/lsh_checker.sv -----
`timescale 1ns / 1ps
module lod_select_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [15:0]                   s_tdata,  // metric
    input  logic [1:0]                    s_tuser,  // cmd
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [7:0]                    m_tdata,  // active_level, zero fill
    input  logic [1:0]                    m_tuser,  // level_valid, applied
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [lsh_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [lsh_pkg::TABLE_W-1:0]   cfg_data,
    output int                            fail_count,
    output int                            pending
);
    import lsh_pkg::*;

    localparam int LEVEL_LIMIT = 4;

    typedef struct packed {
        logic               valid;
        logic [LEVEL_W-1:0] level;
        logic               applied;
    } lod_word_t;

    logic [1:0]          cfg_mode;
    logic [LCOUNT_W-1:0] cfg_levels;
    logic [LEVEL_W-1:0]  cfg_fixed;
    logic [RATIO_W-1:0]  cfg_band;
    logic [TCOUNT_W-1:0] cfg_pcount;
    logic [TABLE_W-1:0]  cfg_ptable;
    logic [TCOUNT_W-1:0] cfg_xcount;
    logic [TABLE_W-1:0]  cfg_xtable;
    logic [LEVEL_W-1:0]  sel_level;
    logic                sel_known;

    lod_word_t level_q[$];
    lod_word_t want;
    int        errors;
    int        words_seen;

    initial begin
        errors     = 0;
        words_seen = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("mismatch on result word %0d, %s: got %0d, expected %0d",
                 words_seen, what, got, exp_val);
        errors++;
    endtask

    // running max over the first count entries, the rest pass through raw
    function automatic logic [2:0][15:0] monotone_limits(logic [TABLE_W-1:0] raw,
                                                         logic [TCOUNT_W-1:0] count);
        logic [2:0][15:0] lim;
        int i;
        for (i = 0; i < TABLE_SLOTS; i++) begin
            lim[i] = raw[i*16 +: 16];
            if (i > 0 && i < count && lim[i] < lim[i-1]) lim[i] = lim[i-1];
        end
        return lim;
    endfunction

    function automatic int distance_level(logic [15:0] m, int lc);
        logic [2:0][15:0] t;
        logic [39:0] lhs, rhs;
        int n, base, last, b;
        t = monotone_limits(cfg_ptable, cfg_pcount);
        n = cfg_pcount;
        base = 0;
        if (n != 0)
            while (base + 1 < lc && base < n && m >= t[base]) base++;
        if (!sel_known) return base;
        last = sel_level;
        if (base == last) return last;
        b = (base < last) ? base : last;
        if (b >= n) return base;
        lhs = 40'(m) << 16;
        if (base > last) begin
            rhs = 40'(t[b]) * (40'd65536 + 40'(cfg_band));
            return (lhs >= rhs) ? base : last;
        end
        rhs = 40'(t[b]) * (40'd65536 - 40'(cfg_band));
        return (lhs <= rhs) ? base : last;
    endfunction

    function automatic int error_level(logic [15:0] m, int lc);
        logic [2:0][15:0] ein, eout;
        int n, k, base, last, b;
        ein  = monotone_limits(cfg_ptable, cfg_pcount);
        eout = monotone_limits(cfg_xtable, cfg_xcount);
        n = cfg_pcount;
        k = cfg_xcount;
        base = 0;
        if (n != 0)
            while (base + 1 < lc && base < n && m < ein[base]) base++;
        if (!sel_known) return base;
        last = sel_level;
        if (base == last) return last;
        b = (base < last) ? base : last;
        if (b >= n || b >= k) return base;
        if (base > last) return (m <= eout[b]) ? base : last;
        return (m >= ein[b]) ? base : last;
    endfunction

    function automatic lod_word_t resolve_word(logic [1:0] cmd, logic [15:0] m);
        lod_word_t w;
        int lc;
        w  = '0;
        lc = cfg_levels;
        if (lc != 0) begin
            if (cmd == CMD_DISTANCE && cfg_mode == MODE_DISTANCE) begin
                sel_level = LEVEL_W'(distance_level(m, lc));
                sel_known = 1'b1;
                w.applied = 1'b1;
            end else if (cmd == CMD_ERROR && cfg_mode == MODE_ERROR) begin
                sel_level = LEVEL_W'(error_level(m, lc));
                sel_known = 1'b1;
                w.applied = 1'b1;
            end
            if (cfg_mode == MODE_FIXED) begin
                w.valid = 1'b1;
                w.level = (cfg_fixed < lc) ? cfg_fixed : LEVEL_W'(lc - 1);
            end else if (sel_known) begin
                w.valid = 1'b1;
                w.level = (sel_level < lc) ? sel_level : LEVEL_W'(lc - 1);
            end
        end
        return w;
    endfunction

    task automatic apply_write(logic [REG_IDX_W-1:0] idx, logic [TABLE_W-1:0] value);
        case (idx)
            REG_LOD_MODE:      cfg_mode   = value[1:0];
            REG_LEVEL_COUNT:   cfg_levels = (value[2:0] > LEVEL_LIMIT) ? LCOUNT_W'(LEVEL_LIMIT)
                                                                       : value[2:0];
            REG_FIXED_LEVEL:   cfg_fixed  = value[1:0];
            REG_BAND_RATIO:    cfg_band   = (value[15:0] > RATIO_MAX) ? RATIO_MAX : value[15:0];
            REG_PRIMARY_COUNT: cfg_pcount = value[1:0];
            REG_PRIMARY_TABLE: cfg_ptable = value;
            REG_EXIT_COUNT:    cfg_xcount = value[1:0];
            REG_EXIT_TABLE:    cfg_xtable = value;
            default: ;
        endcase
        sel_known = 1'b0;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_mode   = MODE_FIXED;
            cfg_levels = '0;
            cfg_fixed  = '0;
            cfg_band   = '0;
            cfg_pcount = '0;
            cfg_ptable = '0;
            cfg_xcount = '0;
            cfg_xtable = '0;
            sel_level  = '0;
            sel_known  = 1'b0;
            level_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
            if (m_tvalid && m_tready) begin
                if (level_q.size() == 0) begin
                    report_mismatch("word with nothing expected", m_tdata, 0);
                end else begin
                    want = level_q.pop_front();
                    if (m_tuser[0] !== want.valid)
                        report_mismatch("level_valid", m_tuser[0], want.valid);
                    if (m_tdata[1:0] !== want.level)
                        report_mismatch("active_level", m_tdata[1:0], want.level);
                    if (m_tdata[7:2] !== 6'd0)
                        report_mismatch("tdata fill", m_tdata[7:2], 0);
                    if (m_tuser[1] !== want.applied)
                        report_mismatch("applied", m_tuser[1], want.applied);
                end
                words_seen++;
            end
            if (s_tvalid && s_tready) level_q.push_back(resolve_word(s_tuser, s_tdata));
        end
        pending    <= level_q.size();
        fail_count <= errors;
    end

endmodule

// ----- test/tb_lod_select_hysteresis.sv -----
`timescale 1ns / 1ps
module tb_lod_select_hysteresis;
    import lsh_pkg::*;

    localparam logic [1:0] MODE_SPARE  = 2'd3;
    localparam logic [1:0] CMD_SPARE   = 2'd3;
    localparam int         PHASES      = 22;
    localparam int         PHASE_WORDS = 35;
    localparam int         HOLD_CYCLES = 80;
    localparam int         CYCLE_LIMIT = 150000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [15:0]          s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [7:0]           m_tdata;
    logic [1:0]           m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [TABLE_W-1:0]   cfg_data;

    int fail_count;
    int pending;

    bit stall_en;
    bit hold_req;

    // current setup, kept for steering the metrics toward the boundaries
    logic [1:0]         su_mode;
    logic [RATIO_W-1:0] su_band;
    logic [TABLE_W-1:0] su_ptab;
    logic [TABLE_W-1:0] su_xtab;

    lod_select_hysteresis i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lod_select_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("simulation failed");
        $finish;
    end

    // receiver: random stalls, or one long hold-off when asked
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                m_tready <= !(stall_en && $urandom_range(0, 99) < 13);
            end
        end
    end

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [TABLE_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic end_writes();
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_word(input logic [1:0] cmd, input logic [15:0] metric);
        int gap;
        @(negedge aclk);
        if (stall_en && $urandom_range(0, 99) < 6) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= metric;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // garbage above the field width now and then, the block must ignore it
    function automatic logic [TABLE_W-1:0] with_junk(logic [TABLE_W-1:0] value, int width);
        logic [TABLE_W-1:0] junk;
        junk = TABLE_W'({$urandom(), $urandom()});
        if ($urandom_range(0, 99) < 30) return (junk << width) | value;
        return value;
    endfunction

    function automatic logic [TABLE_W-1:0] random_table();
        int r, a, b, c, tmp;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 10) return '1;
        if (r < 25) return TABLE_W'({$urandom(), $urandom()});
        a = $urandom_range(0, 65535);
        b = $urandom_range(0, 65535);
        c = $urandom_range(0, 65535);
        if (a > b) begin tmp = a; a = b; b = tmp; end
        if (b > c) begin tmp = b; b = c; c = tmp; end
        if (a > b) begin tmp = a; a = b; b = tmp; end
        return {16'(c), 16'(b), 16'(a)};
    endfunction

    function automatic logic [1:0] random_count();
        if ($urandom_range(0, 99) < 60) return 2'd3;
        return 2'($urandom_range(0, 2));
    endfunction

    task automatic program_setup();
        logic [1:0]         mode;
        logic [2:0]         levels;
        logic [RATIO_W-1:0] band;
        int r;
        r = $urandom_range(0, 99);
        mode = (r < 40) ? MODE_DISTANCE : (r < 80) ? MODE_ERROR :
               (r < 92) ? MODE_FIXED : MODE_SPARE;
        r = $urandom_range(0, 99);
        levels = (r < 5) ? 3'd0 : (r < 12) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(2, 4));
        r = $urandom_range(0, 99);
        band = (r < 10) ? 16'd0 : (r < 20) ? RATIO_MAX :
               (r < 30) ? 16'($urandom_range(64881, 65535)) :
               (r < 65) ? 16'($urandom_range(0, 4000)) : 16'($urandom_range(0, 65535));
        su_mode = mode;
        su_band = (band > RATIO_MAX) ? RATIO_MAX : band;
        su_ptab = random_table();
        su_xtab = random_table();
        write_reg(REG_LOD_MODE,      with_junk(TABLE_W'(mode), 2));
        write_reg(REG_LEVEL_COUNT,   with_junk(TABLE_W'(levels), 3));
        write_reg(REG_FIXED_LEVEL,   with_junk(TABLE_W'($urandom_range(0, 3)), 2));
        write_reg(REG_BAND_RATIO,    with_junk(TABLE_W'(band), 16));
        write_reg(REG_PRIMARY_COUNT, with_junk(TABLE_W'(random_count()), 2));
        write_reg(REG_PRIMARY_TABLE, su_ptab);
        write_reg(REG_EXIT_COUNT,    with_junk(TABLE_W'(random_count()), 2));
        write_reg(REG_EXIT_TABLE,    su_xtab);
        end_writes();
    endtask

    // mostly metrics close to a threshold or to its band edges
    function automatic logic [15:0] pick_metric();
        logic [TABLE_W-1:0] tab;
        int r, slot, t, v;
        r = $urandom_range(0, 99);
        if (r < 3) return 16'h0000;
        if (r < 6) return 16'hFFFF;
        if (r < 40) return 16'($urandom_range(0, 65535));
        tab  = $urandom_range(0, 1) ? su_ptab : su_xtab;
        slot = $urandom_range(0, 2);
        t    = tab[slot*16 +: 16];
        case ($urandom_range(0, 2))
            0:       v = t;
            1:       v = int'((longint'(t) * (65536 + su_band)) >> 16);
            default: v = int'((longint'(t) * (65536 - su_band)) >> 16);
        endcase
        v = v + int'($urandom_range(0, 6)) - 3;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return 16'(v);
    endfunction

    function automatic logic [1:0] pick_cmd();
        if ($urandom_range(0, 99) < 80) begin
            if (su_mode == MODE_DISTANCE) return CMD_DISTANCE;
            if (su_mode == MODE_ERROR) return CMD_ERROR;
        end
        return 2'($urandom_range(0, 3));
    endfunction

    initial begin
        int phase, k, words;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        stall_en  = 1'b1;
        hold_req  = 1'b0;
        su_mode   = MODE_FIXED;
        su_band   = '0;
        su_ptab   = '0;
        su_xtab   = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // nothing configured: no levels, every command just reports
        send_word(CMD_DISTANCE, 16'h0000);
        send_word(CMD_ERROR, 16'hFFFF);
        send_word(CMD_QUERY, 16'h5555);
        send_word(CMD_SPARE, 16'hAAAA);
        wait_drained();

        // fixed mode, level count saturating, then fixed level clamped
        write_reg(REG_LEVEL_COUNT, 48'd7);
        write_reg(REG_FIXED_LEVEL, 48'd3);
        write_reg(REG_LOD_MODE, TABLE_W'(MODE_FIXED));
        end_writes();
        send_word(CMD_QUERY, 16'h0000);
        wait_drained();
        write_reg(REG_LEVEL_COUNT, 48'd2);
        end_writes();
        send_word(CMD_DISTANCE, 16'h0000);
        wait_drained();

        // unknown mode
        write_reg(REG_LOD_MODE, TABLE_W'(MODE_SPARE));
        end_writes();
        send_word(CMD_DISTANCE, 16'h0100);
        wait_drained();

        // distance mode, saturated ratio, non-monotonic table
        write_reg(REG_LOD_MODE, TABLE_W'(MODE_DISTANCE));
        write_reg(REG_LEVEL_COUNT, 48'd4);
        write_reg(REG_BAND_RATIO, 48'hFFFF);
        write_reg(REG_PRIMARY_COUNT, 48'd3);
        write_reg(REG_PRIMARY_TABLE, {16'h0400, 16'h0080, 16'h0100});
        end_writes();
        send_word(CMD_ERROR, 16'h0200);
        send_word(CMD_DISTANCE, 16'hFFFF);
        send_word(CMD_DISTANCE, 16'h0000);
        send_word(CMD_DISTANCE, 16'h0200);
        send_word(CMD_DISTANCE, 16'h0001);
        send_word(CMD_SPARE, 16'h0000);
        wait_drained();
        write_reg(REG_BAND_RATIO, 48'd0);
        end_writes();
        send_word(CMD_DISTANCE, 16'h0100);
        send_word(CMD_DISTANCE, 16'h00FF);
        wait_drained();

        // empty primary table
        write_reg(REG_PRIMARY_COUNT, 48'd0);
        end_writes();
        send_word(CMD_DISTANCE, 16'hFFFF);
        wait_drained();

        // error mode, then boundary past the exit table
        write_reg(REG_LOD_MODE, TABLE_W'(MODE_ERROR));
        write_reg(REG_PRIMARY_COUNT, 48'd3);
        write_reg(REG_PRIMARY_TABLE, {16'h0100, 16'h0200, 16'h0300});
        write_reg(REG_EXIT_COUNT, 48'd1);
        write_reg(REG_EXIT_TABLE, 48'hFFFF_FFFF_FFFF);
        end_writes();
        send_word(CMD_ERROR, 16'hFFFF);
        send_word(CMD_ERROR, 16'h0000);
        send_word(CMD_ERROR, 16'h0400);
        send_word(CMD_DISTANCE, 16'h0000);
        wait_drained();
        write_reg(REG_EXIT_COUNT, 48'd0);
        end_writes();
        send_word(CMD_ERROR, 16'h0000);
        send_word(CMD_ERROR, 16'hFFFF);
        wait_drained();

        for (phase = 0; phase < PHASES; phase++) begin
            program_setup();
            // one phase runs without any idling on either side
            stall_en = (phase != 3);
            words = (phase == 3) ? 3 * PHASE_WORDS : PHASE_WORDS;
            if (phase == 6) hold_req = 1'b1;
            for (k = 0; k < words; k++) begin
                send_word(pick_cmd(), pick_metric());
                if (phase == 9 && k == PHASE_WORDS / 2) wait_drained();
            end
            wait_drained();
        end
        stall_en = 1'b1;

        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
